[hdl/sha256_pkg.sv]
// Shared SHA-256 constants, round functions and control structs.
package sha256_pkg;

	localparam logic [7:0] PAD_BYTE  = 8'h80;
	localparam logic [5:0] LEN_START = 6'd56;
	localparam logic [5:0] LAST_SLOT = 6'd63;

	typedef struct packed {
		logic       shift;
		logic [7:0] byte_in;
		logic       expand;
	} sched_ctl_t;

	typedef struct packed {
		logic       load;
		logic       step;
		logic       fold;
		logic       restart;
		logic [5:0] round;
	} round_ctl_t;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] init_word(input logic [2:0] idx);
		logic [31:0] r;
		case (idx)
			3'd0: r = 32'h6a09e667;
			3'd1: r = 32'hbb67ae85;
			3'd2: r = 32'h3c6ef372;
			3'd3: r = 32'ha54ff53a;
			3'd4: r = 32'h510e527f;
			3'd5: r = 32'h9b05688c;
			3'd6: r = 32'h1f83d9ab;
			default: r = 32'h5be0cd19;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] round_k(input logic [5:0] idx);
		logic [31:0] r;
		case (idx)
			6'd0:  r = 32'h428a2f98;  6'd1:  r = 32'h71374491;
			6'd2:  r = 32'hb5c0fbcf;  6'd3:  r = 32'he9b5dba5;
			6'd4:  r = 32'h3956c25b;  6'd5:  r = 32'h59f111f1;
			6'd6:  r = 32'h923f82a4;  6'd7:  r = 32'hab1c5ed5;
			6'd8:  r = 32'hd807aa98;  6'd9:  r = 32'h12835b01;
			6'd10: r = 32'h243185be;  6'd11: r = 32'h550c7dc3;
			6'd12: r = 32'h72be5d74;  6'd13: r = 32'h80deb1fe;
			6'd14: r = 32'h9bdc06a7;  6'd15: r = 32'hc19bf174;
			6'd16: r = 32'he49b69c1;  6'd17: r = 32'hefbe4786;
			6'd18: r = 32'h0fc19dc6;  6'd19: r = 32'h240ca1cc;
			6'd20: r = 32'h2de92c6f;  6'd21: r = 32'h4a7484aa;
			6'd22: r = 32'h5cb0a9dc;  6'd23: r = 32'h76f988da;
			6'd24: r = 32'h983e5152;  6'd25: r = 32'ha831c66d;
			6'd26: r = 32'hb00327c8;  6'd27: r = 32'hbf597fc7;
			6'd28: r = 32'hc6e00bf3;  6'd29: r = 32'hd5a79147;
			6'd30: r = 32'h06ca6351;  6'd31: r = 32'h14292967;
			6'd32: r = 32'h27b70a85;  6'd33: r = 32'h2e1b2138;
			6'd34: r = 32'h4d2c6dfc;  6'd35: r = 32'h53380d13;
			6'd36: r = 32'h650a7354;  6'd37: r = 32'h766a0abb;
			6'd38: r = 32'h81c2c92e;  6'd39: r = 32'h92722c85;
			6'd40: r = 32'ha2bfe8a1;  6'd41: r = 32'ha81a664b;
			6'd42: r = 32'hc24b8b70;  6'd43: r = 32'hc76c51a3;
			6'd44: r = 32'hd192e819;  6'd45: r = 32'hd6990624;
			6'd46: r = 32'hf40e3585;  6'd47: r = 32'h106aa070;
			6'd48: r = 32'h19a4c116;  6'd49: r = 32'h1e376c08;
			6'd50: r = 32'h2748774c;  6'd51: r = 32'h34b0bcb5;
			6'd52: r = 32'h391c0cb3;  6'd53: r = 32'h4ed8aa4a;
			6'd54: r = 32'h5b9cca4f;  6'd55: r = 32'h682e6ff3;
			6'd56: r = 32'h748f82ee;  6'd57: r = 32'h78a5636f;
			6'd58: r = 32'h84c87814;  6'd59: r = 32'h8cc70208;
			6'd60: r = 32'h90befffa;  6'd61: r = 32'ha4506ceb;
			6'd62: r = 32'hbef9a3f7;
			default: r = 32'hc67178f2;
		endcase
		return r;
	endfunction

endpackage

[hdl/sha256_stream_hasher.sv]
// Top level: streaming SHA-256 hasher with byte input and word-wide digest output.
// Streaming SHA-256 over a byte message. Each input item with tuser = 0 appends the tdata
// byte to the current 64-byte block; after the item that completes a block, tready stays
// low while the block is compressed (64 rounds through the single shared round unit, one
// per cycle, then a fold of the result into the chaining words). An item with tuser = 1
// finishes the message: the padding bytes (0x80, zeros, 64-bit big-endian bit length) are
// pushed through the same byte path one per cycle and the padded block is compressed, with
// a second padded block when more than 55 bytes are pending. The digest then leaves as
// eight output items, word 0 first, tlast on word 7, at one item per cycle under m_tready.
// After the last word the hasher is back at its initial values and takes a new message;
// tready stays low from finish to the last word.
module sha256_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] digest_word
	output logic [2:0]  m_tuser,   // [2:0] word_index
	output logic        m_tlast    // last_word
);
	import sha256_pkg::*;

	localparam logic MODE_FINISH = 1'b1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PAD  = 3'd1;
	localparam logic [2:0] ST_COMP = 3'd2;
	localparam logic [2:0] ST_FOLD = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	localparam logic [2:0] LAST_WORD = 3'd7;

	logic [2:0]  state_q;
	logic [60:0] count_q;    // message bytes, wraps mod 2^61
	logic [5:0]  fill_q;     // bytes in current block
	logic [5:0]  round_q;    // round index, wraps back to 0 after 64 rounds
	logic [2:0]  idx_q;      // digest word being sent
	logic        padding_q;  // finishing a message
	logic        first_q;    // next pad byte is the 0x80 marker
	logic        final_q;    // this block carries the length
	logic [63:0] len_q;      // bit length, top byte goes out next

	logic       in_acc, out_acc;
	logic       len_slot;
	logic       byte_shift, block_full;
	logic [7:0] pad_byte;

	sched_ctl_t  sched_ctl;
	round_ctl_t  round_ctl;
	logic [31:0] w_cur;
	logic [31:0] chain_word;

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign m_tvalid = (state_q == ST_EMIT);
	assign out_acc  = m_tvalid && m_tready;

	// length occupies the last eight slots of the final block
	assign len_slot = !first_q && final_q && (fill_q >= LEN_START);
	assign pad_byte = first_q ? PAD_BYTE : (len_slot ? len_q[63:56] : 8'h00);

	assign byte_shift = (in_acc && (s_tuser != MODE_FINISH)) || (state_q == ST_PAD);
	assign block_full = byte_shift && (fill_q == LAST_SLOT);

	assign sched_ctl.shift   = byte_shift;
	assign sched_ctl.byte_in = (state_q == ST_PAD) ? pad_byte : s_tdata;
	assign sched_ctl.expand  = (state_q == ST_COMP);

	assign round_ctl.load    = block_full;
	assign round_ctl.step    = (state_q == ST_COMP);
	assign round_ctl.fold    = (state_q == ST_FOLD);
	assign round_ctl.restart = out_acc && (idx_q == LAST_WORD);
	assign round_ctl.round   = round_q;

	sha256_sched u_sched (
		.clk   (clk),
		.ctl   (sched_ctl),
		.w_cur (w_cur)
	);

	sha256_round u_round (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (round_ctl),
		.w_cur      (w_cur),
		.word_sel   (idx_q),
		.chain_word (chain_word)
	);

	assign m_tdata = chain_word;
	assign m_tuser = idx_q;
	assign m_tlast = (idx_q == LAST_WORD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			fill_q    <= '0;
			round_q   <= '0;
			idx_q     <= '0;
			padding_q <= 1'b0;
			first_q   <= 1'b0;
			final_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (s_tuser == MODE_FINISH) begin
							padding_q <= 1'b1;
							first_q   <= 1'b1;
							final_q   <= (fill_q < LEN_START);
							state_q   <= ST_PAD;
						end else begin
							count_q <= count_q + 61'd1;
							fill_q  <= fill_q + 6'd1;
							if (block_full) state_q <= ST_COMP;
						end
					end
				end
				ST_PAD: begin
					first_q <= 1'b0;
					fill_q  <= fill_q + 6'd1;
					if (block_full) state_q <= ST_COMP;
				end
				ST_COMP: begin
					round_q <= round_q + 6'd1;
					if (round_q == LAST_SLOT) state_q <= ST_FOLD;
				end
				ST_FOLD: begin
					if (!padding_q) begin
						state_q <= ST_IDLE;
					end else if (final_q) begin
						idx_q   <= '0;
						state_q <= ST_EMIT;
					end else begin
						// overflow block done, the next one carries the length
						final_q <= 1'b1;
						state_q <= ST_PAD;
					end
				end
				ST_EMIT: begin
					if (out_acc) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == LAST_WORD) begin
							count_q   <= '0;
							fill_q    <= '0;
							padding_q <= 1'b0;
							final_q   <= 1'b0;
							state_q   <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// bit length captured on finish, shifted out a byte at a time
	always_ff @(posedge clk) begin
		if (in_acc && (s_tuser == MODE_FINISH)) begin
			len_q <= {count_q, 3'b000};
		end else if ((state_q == ST_PAD) && len_slot) begin
			len_q <= {len_q[55:0], 8'h00};
		end
	end

endmodule

[hdl/sha256_sched.sv]
// Block buffer as a byte shift line that doubles as the 16-word message schedule window.
module sha256_sched (
	input  logic                    clk,
	input  sha256_pkg::sched_ctl_t  ctl,
	output logic [31:0]             w_cur
);
	import sha256_pkg::*;

	// word k of the window sits at bits [511-32k -: 32]
	logic [511:0] win_q;
	logic [31:0]  w_new;

	assign w_cur = win_q[511:480];
	assign w_new = small_sigma1(win_q[511-32*14 -: 32]) + win_q[511-32*9 -: 32]
	             + small_sigma0(win_q[511-32*1 -: 32]) + win_q[511:480];

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			win_q <= {win_q[503:0], ctl.byte_in};
		end else if (ctl.expand) begin
			win_q <= {win_q[479:0], w_new};
		end
	end

endmodule

[hdl/sha256_round.sv]
// Chaining words, working variables and the shared compression round unit.
module sha256_round (
	input  logic                    clk,
	input  logic                    arst_n,
	input  sha256_pkg::round_ctl_t  ctl,
	input  logic [31:0]             w_cur,
	input  logic [2:0]              word_sel,
	output logic [31:0]             chain_word
);
	import sha256_pkg::*;

	logic [31:0] chain_q [8];
	logic [31:0] v_q [8];
	logic [31:0] t1, t2;

	assign t1 = v_q[7] + big_sigma1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
	          + round_k(ctl.round) + w_cur;
	assign t2 = big_sigma0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

	assign chain_word = chain_q[word_sel];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) chain_q[i] <= init_word(3'(i));
		end else if (ctl.restart) begin
			for (int i = 0; i < 8; i++) chain_q[i] <= init_word(3'(i));
		end else if (ctl.fold) begin
			for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + v_q[i];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			for (int i = 0; i < 8; i++) v_q[i] <= chain_q[i];
		end else if (ctl.step) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

endmodule
